@@ hdl/pal_pkg.sv @@
package pal_pkg;

   localparam int CAPACITY = 8;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int FILL_W   = $clog2(CAPACITY + 1);
   localparam int POS_W    = 7;
   localparam int WORD_W   = 32;
   localparam int COUNT_W  = 7;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [FILL_W-1:0] fill_type;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_DUMP   = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      op_type                   operation;
      logic [POS_W-1:0]         position;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic signed [WORD_W-1:0] word;
      logic [COUNT_W-1:0]       count;
      logic                     last;
   } rsp_type;

   // result event from the sequencer; count is attached by the top level
   typedef struct packed {
      logic                     emit;
      status_type               status;
      logic signed [WORD_W-1:0] word;
      logic                     last;
      logic                     grow;
      logic                     shrink;
   } evt_type;

endpackage

@@ hdl/pal_ram.sv @@
module pal_ram
   import pal_pkg::*;
(
   input  logic                     clock,
   input  logic                     wr_en,
   input  idx_type                  wr_addr,
   input  logic signed [WORD_W-1:0] wr_data,
   input  idx_type                  rd_addr,
   output logic signed [WORD_W-1:0] rd_data
);

   logic signed [WORD_W-1:0] mem [CAPACITY];
   logic signed [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/pal_ctrl.sv @@
module pal_ctrl
   import pal_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  req_type                  req,
   input  fill_type                 fill,
   output logic                     busy,
   output logic                     wr_en,
   output idx_type                  wr_addr,
   output logic signed [WORD_W-1:0] wr_data,
   output idx_type                  rd_addr,
   input  logic signed [WORD_W-1:0] rd_data,
   output evt_type                  evt
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_WR,
      S_INS_PUT,
      S_DEL_RD,
      S_DEL_GRAB,
      S_SH_RD,
      S_SH_WR,
      S_DUMP_RD,
      S_DUMP_OUT,
      S_REPLY
   } state_type;

   state_type                state_ff, state_in;
   idx_type                  ptr_ff, ptr_in;
   idx_type                  key_ff, key_in;
   logic signed [WORD_W-1:0] val_ff, val_in;
   logic signed [WORD_W-1:0] word_ff, word_in;
   op_type                   op_ff, op_in;
   status_type               status_ff, status_in;

   logic [POS_W-1:0] fill_pos;
   fill_type         ptr_ext;
   logic             full;
   logic             empty;

   assign fill_pos = POS_W'(fill);
   assign ptr_ext  = FILL_W'(ptr_ff);
   assign full     = (fill == FILL_W'(CAPACITY));
   assign empty    = (fill == '0);
   assign busy     = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      key_in    = key_ff;
      val_in    = val_ff;
      word_in   = word_ff;
      op_in     = op_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = ptr_ff;
      wr_data   = rd_data;
      rd_addr   = ptr_ff;
      evt       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = req.operation;
               val_in    = req.value;
               word_in   = '0;
               status_in = ST_OK;
               key_in    = IDX_W'(req.position - POS_W'(1));
               unique case (req.operation)
                  OP_INSERT: begin
                     ptr_in = IDX_W'(fill);
                     if (full) begin
                        status_in = ST_FULL;
                        state_in  = S_REPLY;
                     end else if (req.position == '0 ||
                                  req.position > fill_pos + POS_W'(1)) begin
                        status_in = ST_RANGE;
                        state_in  = S_REPLY;
                     end else if (fill_pos == req.position - POS_W'(1)) begin
                        state_in = S_INS_PUT;
                     end else begin
                        state_in = S_INS_RD;
                     end
                  end
                  OP_DELETE: begin
                     ptr_in = IDX_W'(req.position - POS_W'(1));
                     if (empty) begin
                        status_in = ST_EMPTY;
                        state_in  = S_REPLY;
                     end else if (req.position == '0 || req.position > fill_pos) begin
                        status_in = ST_RANGE;
                        state_in  = S_REPLY;
                     end else begin
                        state_in = S_DEL_RD;
                     end
                  end
                  OP_DUMP: begin
                     ptr_in = '0;
                     if (empty) begin
                        status_in = ST_EMPTY;
                        state_in  = S_REPLY;
                     end else begin
                        state_in = S_DUMP_RD;
                     end
                  end
                  default: begin
                     state_in = S_REPLY;
                  end
               endcase
            end
         end
         // open a hole: move entry ptr-1 up to ptr
         S_INS_RD: begin
            rd_addr  = ptr_ff - IDX_W'(1);
            state_in = S_INS_WR;
         end
         S_INS_WR: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = rd_data;
            ptr_in  = ptr_ff - IDX_W'(1);
            if (ptr_ff - IDX_W'(1) == key_ff) begin
               state_in = S_INS_PUT;
            end else begin
               state_in = S_INS_RD;
            end
         end
         S_INS_PUT: begin
            wr_en      = 1'b1;
            wr_addr    = key_ff;
            wr_data    = val_ff;
            evt.emit   = 1'b1;
            evt.status = ST_OK;
            evt.last   = 1'b1;
            evt.grow   = 1'b1;
            state_in   = S_IDLE;
         end
         S_DEL_RD: begin
            rd_addr  = ptr_ff;
            state_in = S_DEL_GRAB;
         end
         S_DEL_GRAB: begin
            word_in = rd_data;
            if (ptr_ext + FILL_W'(1) == fill) begin
               state_in = S_REPLY;
            end else begin
               state_in = S_SH_RD;
            end
         end
         // close the gap: move entry ptr+1 down to ptr
         S_SH_RD: begin
            rd_addr  = ptr_ff + IDX_W'(1);
            state_in = S_SH_WR;
         end
         S_SH_WR: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = rd_data;
            ptr_in  = ptr_ff + IDX_W'(1);
            if (ptr_ext + FILL_W'(2) == fill) begin
               state_in = S_REPLY;
            end else begin
               state_in = S_SH_RD;
            end
         end
         S_DUMP_RD: begin
            rd_addr  = ptr_ff;
            state_in = S_DUMP_OUT;
         end
         S_DUMP_OUT: begin
            evt.emit   = 1'b1;
            evt.status = ST_OK;
            evt.word   = rd_data;
            evt.last   = (ptr_ext + FILL_W'(1) == fill);
            ptr_in     = ptr_ff + IDX_W'(1);
            if (ptr_ext + FILL_W'(1) == fill) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_DUMP_RD;
            end
         end
         S_REPLY: begin
            evt.emit   = 1'b1;
            evt.status = status_ff;
            evt.word   = word_ff;
            evt.last   = 1'b1;
            evt.shrink = (op_ff == OP_DELETE) && (status_ff == ST_OK);
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ptr_ff    <= ptr_in;
      key_ff    <= key_in;
      val_ff    <= val_in;
      word_ff   <= word_in;
      op_ff     <= op_in;
      status_ff <= status_in;
   end

endmodule

@@ hdl/positional_array_list_unit.sv @@
// Channel   Ports                        Handshake
// command   start, busy, req_data        taken when start && !busy
// result    rsp_valid, rsp_data          one-cycle strobe, cannot be held off
//
// Entries sit in a RAM with a registered read; the sequencer moves one entry at a time, read then write.
// Insert at p shifts entries p..n up, then writes the word; delete reads entry p, shifts the rest down.
// Dump reads and sends each entry in turn. Errors and the unused code answer from the reply state.
// Results leave through one register; busy falls in the cycle the final result shows.
// reset (synchronous) empties the list; entry contents are not cleared.
// The receiver cannot stall, so nothing ever waits on the result side.
module positional_array_list_unit
   import pal_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   fill_type                 fill_ff, fill_in;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff, rsp_data_in;
   evt_type                  evt;
   logic                     wr_en;
   idx_type                  wr_addr;
   logic signed [WORD_W-1:0] wr_data;
   idx_type                  rd_addr;
   logic signed [WORD_W-1:0] rd_data;

   pal_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req     (req_data),
      .fill    (fill_ff),
      .busy    (busy),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .evt     (evt)
   );

   pal_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // list length moves only when a transaction completes successfully
   always_comb begin
      fill_in = fill_ff;
      if (evt.emit && evt.grow) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (evt.emit && evt.shrink) begin
         fill_in = fill_ff - FILL_W'(1);
      end
      rsp_data_in.status = evt.status;
      rsp_data_in.word   = evt.word;
      rsp_data_in.count  = COUNT_W'(fill_in);
      rsp_data_in.last   = evt.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= evt.emit;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ test/tb_top.sv @@
module tb_top;
   import pal_pkg::*;

   // Watchdog: cycles in a row with no command taken and no result seen.
   localparam int STALL_LIMIT = 1000;
   // Quiet time after the last result.
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 395;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   positional_array_list_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // One row of the directed sequence. When typed is set, the reply is the
   // single transaction given by st/wd/cnt (last is always 1 for those rows);
   // otherwise the shadow list supplies the replies.
   typedef struct packed {
      op_type           op;
      logic [POS_W-1:0] pos;
      logic [31:0]      val;
      logic             typed;
      status_type       st;
      logic [31:0]      wd;
      logic [6:0]       cnt;
   } cmd_row_type;

   cmd_row_type directed_rows [25] = '{
      // empty list: dump, delete, inserts off either end
      '{OP_DUMP,   7'd0,   32'h0000_0000, 1'b1, ST_EMPTY, 32'h0, 7'd0},
      '{OP_DELETE, 7'd1,   32'h0000_0000, 1'b1, ST_EMPTY, 32'h0, 7'd0},
      '{OP_INSERT, 7'd0,   32'h0000_0001, 1'b1, ST_RANGE, 32'h0, 7'd0},
      '{OP_INSERT, 7'd2,   32'h0000_0001, 1'b1, ST_RANGE, 32'h0, 7'd0},
      // extreme words at head, tail and middle
      '{OP_INSERT, 7'd1,   32'h7FFF_FFFF, 1'b1, ST_OK,    32'h0, 7'd1},
      '{OP_INSERT, 7'd2,   32'h8000_0000, 1'b1, ST_OK,    32'h0, 7'd2},
      '{OP_INSERT, 7'd1,   32'hFFFF_FFFF, 1'b1, ST_OK,    32'h0, 7'd3},
      '{OP_INSERT, 7'd2,   32'h0000_0000, 1'b1, ST_OK,    32'h0, 7'd4},
      // unused code leaves the list alone
      '{OP_NOP,    7'd127, 32'hDEAD_BEEF, 1'b1, ST_OK,    32'h0, 7'd4},
      '{OP_DUMP,   7'd127, 32'hFFFF_FFFF, 1'b0, ST_OK,    32'h0, 7'd0},
      '{OP_INSERT, 7'd127, 32'h0000_0005, 1'b1, ST_RANGE, 32'h0, 7'd4},
      '{OP_INSERT, 7'd6,   32'h0000_0005, 1'b1, ST_RANGE, 32'h0, 7'd4},
      // fill up to capacity
      '{OP_INSERT, 7'd5,   32'h00BC_614E, 1'b1, ST_OK,    32'h0, 7'd5},
      '{OP_INSERT, 7'd3,   32'h5555_5555, 1'b1, ST_OK,    32'h0, 7'd6},
      '{OP_INSERT, 7'd1,   32'hAAAA_AAAA, 1'b1, ST_OK,    32'h0, 7'd7},
      '{OP_INSERT, 7'd8,   32'h0000_0001, 1'b1, ST_OK,    32'h0, 7'd8},
      // full beats a bad position
      '{OP_INSERT, 7'd1,   32'h0000_0002, 1'b1, ST_FULL,  32'h0, 7'd8},
      '{OP_INSERT, 7'd0,   32'h0000_0002, 1'b1, ST_FULL,  32'h0, 7'd8},
      '{OP_DUMP,   7'd0,   32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
      // deletes: out of range, tail, head
      '{OP_DELETE, 7'd0,   32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 7'd8},
      '{OP_DELETE, 7'd9,   32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 7'd8},
      '{OP_DELETE, 7'd8,   32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
      '{OP_DELETE, 7'd1,   32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
      '{OP_DELETE, 7'd127, 32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 7'd6},
      '{OP_DUMP,   7'd0,   32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0}
   };

   // Shadow copy of the list, advanced when a command transaction is taken.
   logic signed [WORD_W-1:0] shadow_words [CAPACITY];
   int unsigned              shadow_fill;

   rsp_type cmd_replies  [$];   // replies of the command just applied
   rsp_type replies_due  [$];   // replies still awaited from the unit
   int      error_count;
   int      burst_left;

   // Applies one command to the shadow list and leaves its replies in
   // cmd_replies, in the order the unit must emit them.
   function automatic void apply_to_shadow(req_type cmd);
      rsp_type     r;
      int unsigned p;
      int unsigned i;
      cmd_replies.delete();
      p = cmd.position;
      r = '0;
      r.status = ST_OK;
      r.last = 1'b1;
      case (cmd.operation)
         OP_INSERT: begin
            if (shadow_fill >= CAPACITY) begin
               r.status = ST_FULL;
            end else if (p < 1 || p > shadow_fill + 1) begin
               r.status = ST_RANGE;
            end else begin
               for (i = shadow_fill; i > p - 1; i--) shadow_words[i] = shadow_words[i-1];
               shadow_words[p-1] = cmd.value;
               shadow_fill++;
            end
         end
         OP_DELETE: begin
            if (shadow_fill == 0) begin
               r.status = ST_EMPTY;
            end else if (p < 1 || p > shadow_fill) begin
               r.status = ST_RANGE;
            end else begin
               r.word = shadow_words[p-1];
               for (i = p - 1; i + 1 < shadow_fill; i++) shadow_words[i] = shadow_words[i+1];
               shadow_fill--;
            end
         end
         OP_DUMP: begin
            if (shadow_fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               // one transaction per held entry, last only on the final one
               for (i = 0; i < shadow_fill; i++) begin
                  r.word = shadow_words[i];
                  r.count = COUNT_W'(shadow_fill);
                  r.last = (i + 1 == shadow_fill);
                  cmd_replies.push_back(r);
               end
               return;
            end
         end
         default: ;
      endcase
      r.count = COUNT_W'(shadow_fill);
      cmd_replies.push_back(r);
   endfunction

   // Sender pacing: bursts of back-to-back commands separated by idle gaps.
   // A gap of zero lets two bursts run together into a longer stretch.
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   // Presents one command on the falling edge and holds it until a rising
   // edge sees start with busy low; the replies are queued at that edge.
   task automatic issue(req_type cmd, bit typed, rsp_type typed_rsp);
      int n;
      pace();
      @(negedge clock);
      start <= 1'b1;
      req_data <= cmd;
      @(posedge clock);
      while (busy) @(posedge clock);
      apply_to_shadow(cmd);
      if (typed) begin
         replies_due.push_back(typed_rsp);
      end else begin
         for (n = 0; n < cmd_replies.size(); n++) replies_due.push_back(cmd_replies[n]);
      end
   endtask

   // Result side: the unit strobes each transaction for one cycle, so every
   // rising edge with rsp_valid high is checked against the oldest reply due.
   always @(posedge clock) begin : reply_check
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (replies_due.size() == 0) begin
            $error("unexpected result: status %0d word %0d count %0d last %0d",
                   rsp_data.status, rsp_data.word, rsp_data.count, rsp_data.last);
            error_count++;
         end else begin
            want = replies_due.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.word !== want.word) begin
               $error("word: expected %0d, got %0d", want.word, rsp_data.word);
               error_count++;
            end
            if (rsp_data.count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_data.count);
               error_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_data.last);
               error_count++;
            end
         end
      end
   end

   // Watchdog: any cycle that moves a transaction either way resets it.
   always @(posedge clock) begin : stall_watch
      int idle_run;
      if (reset || (start && !busy) || rsp_valid) begin
         idle_run = 0;
      end else begin
         idle_run++;
         if (idle_run >= STALL_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   initial begin
      req_type cmd;
      rsp_type typed_rsp;
      int      n;
      int      sent;
      int      roll;
      int      ins_cut;
      int      del_cut;
      bit      grow;

      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      shadow_fill = 0;
      error_count = 0;
      burst_left = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed sequence: empty list, extremes, full list, error codes.
      for (n = 0; n < 25; n++) begin
         cmd.operation = directed_rows[n].op;
         cmd.position = directed_rows[n].pos;
         cmd.value = directed_rows[n].val;
         typed_rsp.status = directed_rows[n].st;
         typed_rsp.word = directed_rows[n].wd;
         typed_rsp.count = directed_rows[n].cnt;
         typed_rsp.last = 1'b1;
         issue(cmd, directed_rows[n].typed, typed_rsp);
      end

      // Random part. The mix leans toward inserts while growing and toward
      // deletes while shrinking, so the list keeps sweeping empty to full.
      // Most positions are legal for the current fill; the rest are noise.
      grow = 1'b1;
      sent = 0;
      typed_rsp = '0;
      while (sent < RANDOM_ITEMS) begin
         if (shadow_fill >= CAPACITY) grow = 1'b0;
         else if (shadow_fill == 0) grow = 1'b1;
         else if ($urandom_range(0, 39) == 0) grow = !grow;
         ins_cut = grow ? 60 : 25;
         del_cut = ins_cut + (grow ? 20 : 55);
         roll = $urandom_range(0, 99);
         if (roll < ins_cut) cmd.operation = OP_INSERT;
         else if (roll < del_cut) cmd.operation = OP_DELETE;
         else if (roll < 96) cmd.operation = OP_DUMP;
         else cmd.operation = OP_NOP;

         if ($urandom_range(0, 99) < 15) begin
            cmd.position = POS_W'($urandom_range(0, 127));
         end else if (cmd.operation == OP_INSERT) begin
            cmd.position = POS_W'($urandom_range(1, shadow_fill + 1));
         end else if (cmd.operation == OP_DELETE && shadow_fill > 0) begin
            cmd.position = POS_W'($urandom_range(1, shadow_fill));
         end else begin
            cmd.position = POS_W'($urandom_range(0, 127));
         end

         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
               0: cmd.value = 32'sh7FFF_FFFF;
               1: cmd.value = 32'sh8000_0000;
               2: cmd.value = 32'sh0000_0000;
               default: cmd.value = -32'sd1;
            endcase
         end else begin
            cmd.value = $urandom;
         end

         issue(cmd, 1'b0, typed_rsp);
         sent++;
      end

      @(negedge clock);
      start <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && replies_due.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
